// ----- rtl/match_fragment_builder_assert.svh -----
// ----------------------------------------------------------------------------
// Match fragment builder assertion macros
// Shared helpers for the concurrent assertions of the fragment builder.
// ----------------------------------------------------------------------------
`ifndef MATCH_FRAGMENT_BUILDER_ASSERT_SVH
`define MATCH_FRAGMENT_BUILDER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define MFB_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define MFB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define MFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Match fragment builder package
// Shared types, field widths, codes and saturating helpers.
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int S_TDATA_W  = 88;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 176;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_MATCH = 2'd1;
    localparam logic [1:0] KIND_EOD   = 2'd2;

    localparam logic REC_LOC = 1'b0;
    localparam logic REC_SUM = 1'b1;

    localparam logic REG_MAX_DISTANCE   = 1'b0;
    localparam logic [15:0] MAX_DIST_RST = 16'd8;

    typedef struct packed {
        logic        has_sum;
        logic        has_loc;
        logic [15:0] sum_index;
        logic [23:0] start;
        logic [23:0] bytes;
        logic [23:0] score;
        logic [15:0] match_cnt;
        logic [23:0] tokens;
        logic [15:0] loc_index;
        logic [4:0]  term;
        logic [23:0] offset;
        logic [15:0] len;
    } t_entry;

    typedef struct packed {
        logic        kind;
        logic        last;
        logic [15:0] index;
        logic [4:0]  term;
        logic [23:0] offset;
        logic [15:0] len;
        logic [23:0] start;
        logic [23:0] bytes;
        logic [23:0] score;
        logic [15:0] match_cnt;
        logic [23:0] tokens;
    } t_record;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [23:0] sat24(input logic [25:0] v);
        return (v > 26'h0FF_FFFF) ? 24'hFF_FFFF : v[23:0];
    endfunction

endpackage

// ----- rtl/mfb_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Match fragment builder configuration registers
// APB slave holding the maximum token distance of a fragment.
// ----------------------------------------------------------------------------
module mfb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mfb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mfb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [15:0]                    o_max_dist
);
    import mfb_pkg::*;

    logic [15:0] r_max_dist;
    logic        sel_dist;

    assign sel_dist = (paddr[2] == REG_MAX_DISTANCE);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= MAX_DIST_RST;
        end else if (psel && penable && pwrite && sel_dist) begin
            r_max_dist <= pwdata[15:0];
        end
    end

    assign prdata     = sel_dist ? {16'd0, r_max_dist} : '0;
    assign o_max_dist = r_max_dist;

endmodule

// ----- rtl/mfb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Match fragment builder front end
// Accepts tokens, filters duplicates, tracks the open fragment and queues
// the records that each request produces.
// ----------------------------------------------------------------------------
module mfb_front #(
    parameter int MAX_TERMS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [15:0]                   i_max_dist,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mfb_pkg::S_TDATA_W-1:0] i_data,
    input  logic [mfb_pkg::S_TUSER_W-1:0] i_kind,
    input  logic                          i_full,
    output logic                          o_push,
    output mfb_pkg::t_entry               o_entry
);
    import mfb_pkg::*;

    localparam int TIW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    logic                 r_open, n_open;
    logic [15:0]          r_frag_cnt, n_frag_cnt;
    logic [23:0]          r_start, n_start;
    logic [23:0]          r_bytes, n_bytes;
    logic [23:0]          r_last_match, n_last_match;
    logic [23:0]          r_score, n_score;
    logic [15:0]          r_matches, n_matches;
    logic [23:0]          r_tokens, n_tokens;
    logic [MAX_TERMS-1:0] r_seen, n_seen;
    logic [23:0]          r_gap, n_gap;
    logic                 r_prev_valid, n_prev_valid;
    logic [23:0]          r_prev_pos, n_prev_pos;
    logic [23:0]          r_prev_end, n_prev_end;

    logic [4:0]           term;
    logic [23:0]          tok_pos, byte_pos;
    logic [15:0]          tok_len, weight;
    logic                 accept, take, split, opening, in_range, add_score;
    logic [31:0]          term_ext;
    logic [TIW-1:0]       idx;
    logic [23:0]          pos_gap, start_base, score_base, tokens_base, gap_base, offs;
    logic [15:0]          matches_base, idx_new;
    logic [MAX_TERMS-1:0] seen_base, term_bit;
    logic [24:0]          score_sum;

    assign term     = i_data[4:0];
    assign tok_pos  = i_data[28:5];
    assign byte_pos = i_data[52:29];
    assign tok_len  = i_data[68:53];
    assign weight   = i_data[84:69];

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign take = (i_kind == KIND_MATCH) && !(r_prev_valid && tok_pos == r_prev_pos) &&
                  !(byte_pos < r_prev_end);
    assign pos_gap = tok_pos - r_last_match;
    assign split   = r_open && ((tok_pos < r_last_match) || (pos_gap > {8'd0, i_max_dist}));
    assign opening = !r_open || split;

    assign idx_new      = !r_open ? 16'd0 : (split ? sat_inc16(r_frag_cnt) : r_frag_cnt);
    assign start_base   = opening ? byte_pos : r_start;
    assign score_base   = opening ? 24'd0 : r_score;
    assign matches_base = opening ? 16'd0 : r_matches;
    assign tokens_base  = opening ? 24'd0 : r_tokens;
    assign gap_base     = opening ? 24'd0 : r_gap;
    assign seen_base    = opening ? '0 : r_seen;

    assign term_ext  = 32'(term);
    assign in_range  = term_ext < 32'(MAX_TERMS);
    assign idx       = term_ext[TIW-1:0];
    assign term_bit  = in_range ? (MAX_TERMS'(1) << idx) : '0;
    assign add_score = !(in_range && seen_base[idx]);
    assign score_sum = {1'b0, score_base} + 25'(weight);
    assign offs      = (byte_pos >= start_base) ? byte_pos - start_base : 24'd0;

    always_comb begin
        n_open       = r_open;
        n_frag_cnt   = r_frag_cnt;
        n_start      = r_start;
        n_bytes      = r_bytes;
        n_last_match = r_last_match;
        n_score      = r_score;
        n_matches    = r_matches;
        n_tokens     = r_tokens;
        n_seen       = r_seen;
        n_gap        = r_gap;
        n_prev_valid = r_prev_valid;
        n_prev_pos   = r_prev_pos;
        n_prev_end   = r_prev_end;
        o_push       = 1'b0;

        o_entry.has_sum   = split;
        o_entry.has_loc   = 1'b1;
        o_entry.sum_index = r_frag_cnt;
        o_entry.start     = r_start;
        o_entry.bytes     = r_bytes;
        o_entry.score     = r_score;
        o_entry.match_cnt = r_matches;
        o_entry.tokens    = r_tokens;
        o_entry.loc_index = idx_new;
        o_entry.term      = term;
        o_entry.offset    = offs;
        o_entry.len       = tok_len;

        if (accept) begin
            case (i_kind)
                KIND_TOKEN: begin
                    n_gap = sat24({2'b00, r_gap} + 26'd1);
                end
                KIND_MATCH: begin
                    if (take) begin
                        o_push       = 1'b1;
                        n_open       = 1'b1;
                        n_frag_cnt   = idx_new;
                        n_start      = start_base;
                        n_score      = add_score ? sat24({1'b0, score_sum}) : score_base;
                        n_seen       = seen_base | term_bit;
                        n_bytes      = sat24(26'(offs) + 26'(tok_len));
                        n_last_match = tok_pos;
                        n_matches    = sat_inc16(matches_base);
                        n_tokens     = sat24(26'(tokens_base) + 26'(gap_base) + 26'd1);
                        n_gap        = 24'd0;
                        n_prev_valid = 1'b1;
                        n_prev_pos   = tok_pos;
                        n_prev_end   = sat24(26'(byte_pos) + 26'(tok_len));
                    end
                end
                KIND_EOD: begin
                    o_push          = r_open;
                    o_entry.has_sum = 1'b1;
                    o_entry.has_loc = 1'b0;
                    n_open          = 1'b0;
                    n_frag_cnt      = 16'd0;
                    n_seen          = '0;
                    n_gap           = 24'd0;
                    n_prev_valid    = 1'b0;
                    n_prev_pos      = 24'd0;
                    n_prev_end      = 24'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_frag_cnt   <= 16'd0;
            r_start      <= 24'd0;
            r_bytes      <= 24'd0;
            r_last_match <= 24'd0;
            r_score      <= 24'd0;
            r_matches    <= 16'd0;
            r_tokens     <= 24'd0;
            r_seen       <= '0;
            r_gap        <= 24'd0;
            r_prev_valid <= 1'b0;
            r_prev_pos   <= 24'd0;
            r_prev_end   <= 24'd0;
        end else begin
            r_open       <= n_open;
            r_frag_cnt   <= n_frag_cnt;
            r_start      <= n_start;
            r_bytes      <= n_bytes;
            r_last_match <= n_last_match;
            r_score      <= n_score;
            r_matches    <= n_matches;
            r_tokens     <= n_tokens;
            r_seen       <= n_seen;
            r_gap        <= n_gap;
            r_prev_valid <= n_prev_valid;
            r_prev_pos   <= n_prev_pos;
            r_prev_end   <= n_prev_end;
        end
    end

endmodule

// ----- rtl/mfb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Match fragment builder queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module mfb_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mfb_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output mfb_pkg::t_entry o_head
);
    import mfb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/mfb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Match fragment builder back end
// Expands queued entries into summary and location records and holds the
// output register of the result stream.
// ----------------------------------------------------------------------------
module mfb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  mfb_pkg::t_entry               i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mfb_pkg::M_TDATA_W-1:0] o_data,
    output logic                          o_kind,
    output logic                          o_last
);
    import mfb_pkg::*;

    logic    r_valid, n_valid;
    logic    r_pend, n_pend;
    t_record r_rec, n_rec;
    t_entry  r_hold, n_hold;
    logic    can_load;

    function automatic t_record loc_rec(input t_entry e);
        t_record r;
        r        = '0;
        r.kind   = REC_LOC;
        r.last   = 1'b1;
        r.index  = e.loc_index;
        r.term   = e.term;
        r.offset = e.offset;
        r.len    = e.len;
        return r;
    endfunction

    function automatic t_record sum_rec(input t_entry e);
        t_record r;
        r           = '0;
        r.kind      = REC_SUM;
        r.last      = !e.has_loc;
        r.index     = e.sum_index;
        r.start     = e.start;
        r.bytes     = e.bytes;
        r.score     = e.score;
        r.match_cnt = e.match_cnt;
        r.tokens    = e.tokens;
        return r;
    endfunction

    assign can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        n_rec   = r_rec;
        n_hold  = r_hold;
        o_pop   = 1'b0;
        if (can_load) begin
            if (r_pend) begin
                n_rec   = loc_rec(r_hold);
                n_valid = 1'b1;
                n_pend  = 1'b0;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_hold  = i_head;
                if (i_head.has_sum) begin
                    n_rec  = sum_rec(i_head);
                    n_pend = i_head.has_loc;
                end else begin
                    n_rec = loc_rec(i_head);
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec  <= n_rec;
        r_hold <= n_hold;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_rec.kind;
    assign o_last  = r_rec.last;
    assign o_data  = {3'b000, r_rec.tokens, r_rec.match_cnt, r_rec.score, r_rec.bytes,
                      r_rec.start, r_rec.len, r_rec.offset, r_rec.term, r_rec.index};

endmodule

// ----- rtl/match_fragment_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Match fragment builder
// Groups matched query terms of a token stream into scored fragments.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser holds the token kind and tdata
// the term, token position, byte offset, length and score. Results leave on
// the m_axis channel: tuser is the record kind (location or fragment summary)
// and tlast marks the final record produced by one request.
// The front end takes one request per clock cycle while the queue is not full
// and updates the fragment state in that cycle; its records enter a queue of
// QUEUE_DEPTH entries. The first record of a request passes through the queue
// and then the output register before it is valid on m_axis. A request that
// splits a fragment yields two records; all others yield at most one.
// When the receiver stalls, records wait in the output register and then in
// the queue; s_axis_tready falls once the queue is full.
// Reset empties the queue and the output, closes any fragment, clears the
// filters and counters, and sets max_distance (APB address 0) to 8.
// ----------------------------------------------------------------------------
module match_fragment_builder #(
    parameter int MAX_TERMS   = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // term_id[4:0], tok_pos[28:5], byte_pos[52:29], tok_len[68:53], score[84:69]
    input  logic [mfb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [mfb_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // frag_index[15:0], loc_term[20:16], loc_offset[44:21], loc_len[60:45],
    // frag_start[84:61], frag_bytes[108:85], frag_score[132:109],
    // match_count[148:133], token_total[172:149]
    output logic [mfb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // record_kind[0]
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mfb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mfb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mfb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import mfb_pkg::*;

    logic [15:0] max_dist;
    logic        q_full, q_empty, q_push, q_pop, rec_kind;
    t_entry      push_entry, head_entry;

    mfb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_max_dist (max_dist)
    );

    mfb_front #(.MAX_TERMS(MAX_TERMS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_max_dist (max_dist),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .i_kind     (s_axis_tuser),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_entry    (push_entry)
    );

    mfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    mfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_entry),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_kind  (rec_kind),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tuser = rec_kind;

endmodule

// ----- rtl/mfb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Match fragment builder checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "match_fragment_builder_assert.svh"

module mfb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mfb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                    m_axis_tuser,
    input logic                          m_axis_tlast
);
    import mfb_pkg::*;

    `MFB_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
        $stable(m_axis_tlast),
        "Result changed while stalled.")

    `MFB_ASSERT_IMPL(a_loc_last, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[0] == REC_LOC, m_axis_tlast,
        "Location record without tlast.")

    `MFB_ASSERT_IMPL(a_loc_clean, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[0] == REC_LOC, m_axis_tdata[175:61] == '0,
        "Location record carries summary fields.")

    `MFB_ASSERT_IMPL(a_sum_clean, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[0] == REC_SUM, m_axis_tdata[60:16] == '0,
        "Summary record carries location fields.")

    `MFB_ASSERT_NEXT(a_split_pair, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && m_axis_tuser[0] == REC_SUM && !m_axis_tlast,
        m_axis_tvalid && m_axis_tuser[0] == REC_LOC,
        "Split summary not followed by its location record.")

endmodule

bind match_fragment_builder mfb_checker u_mfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Match fragment builder testbench
// Drives token requests on the input stream and checks every record on the
// output stream against a fragment tracker that mirrors the block's grouping,
// duplicate filtering, scoring and saturation. max_distance is changed over
// several phases, always while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import mfb_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    class frag_record_checker;
        t_record        pending_records[$];
        int             errors;
        int             seen_records;
        logic    [15:0] max_dist;
        bit             open;
        logic    [15:0] frag_idx;
        logic    [23:0] start;
        logic    [23:0] span;
        logic    [23:0] last_match;
        logic    [23:0] score;
        logic    [15:0] match_cnt;
        logic    [23:0] tokens;
        logic    [31:0] terms_seen;
        logic    [23:0] gap;
        bit             prev_valid;
        logic    [23:0] prev_pos;
        logic    [23:0] prev_end;

        function new();
            errors = 0;
            seen_records = 0;
            max_dist = MAX_DIST_RST;
            open = 0;
            frag_idx = '0;
            start = '0;
            span = '0;
            last_match = '0;
            score = '0;
            match_cnt = '0;
            tokens = '0;
            terms_seen = '0;
            gap = '0;
            prev_valid = 0;
            prev_pos = '0;
            prev_end = '0;
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        function logic [23:0] clip24(logic [25:0] v);
            return (v > 26'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
        endfunction

        function t_record summary_record(logic lst);
            t_record r;
            r = '0;
            r.kind = REC_SUM;
            r.last = lst;
            r.index = frag_idx;
            r.start = start;
            r.bytes = span;
            r.score = score;
            r.match_cnt = match_cnt;
            r.tokens = tokens;
            return r;
        endfunction

        function void note_request(logic [1:0] kind, logic [4:0] term, logic [23:0] pos,
                                   logic [23:0] bpos, logic [15:0] len, logic [15:0] wt);
            t_record     r;
            logic [23:0] offs;
            bit          split;
            case (kind)
                KIND_TOKEN: begin
                    gap = clip24({2'b0, gap} + 26'd1);
                end
                KIND_MATCH: begin
                    if (prev_valid && pos == prev_pos)
                        return;
                    if (bpos < prev_end)
                        return;
                    if (open) begin
                        split = (pos < last_match) || ((pos - last_match) > {8'b0, max_dist});
                        if (split) begin
                            pending_records.push_back(summary_record(1'b0));
                            if (frag_idx != 16'hFFFF)
                                frag_idx = frag_idx + 16'd1;
                            open = 0;
                        end
                    end else begin
                        frag_idx = '0;
                    end
                    if (!open) begin
                        open = 1;
                        start = bpos;
                        span = '0;
                        score = '0;
                        match_cnt = '0;
                        tokens = '0;
                        terms_seen = '0;
                        gap = '0;
                    end
                    if (!terms_seen[term]) begin
                        score = clip24({2'b0, score} + {10'b0, wt});
                        terms_seen[term] = 1'b1;
                    end
                    offs = (bpos >= start) ? bpos - start : 24'd0;
                    span = clip24({2'b0, offs} + {10'b0, len});
                    last_match = pos;
                    if (match_cnt != 16'hFFFF)
                        match_cnt = match_cnt + 16'd1;
                    tokens = clip24({2'b0, tokens} + {2'b0, gap} + 26'd1);
                    gap = '0;
                    prev_pos = pos;
                    prev_valid = 1;
                    prev_end = clip24({2'b0, bpos} + {10'b0, len});
                    r = '0;
                    r.kind = REC_LOC;
                    r.last = 1'b1;
                    r.index = frag_idx;
                    r.term = term;
                    r.offset = offs;
                    r.len = len;
                    pending_records.push_back(r);
                end
                KIND_EOD: begin
                    if (open)
                        pending_records.push_back(summary_record(1'b1));
                    open = 0;
                    frag_idx = '0;
                    terms_seen = '0;
                    gap = '0;
                    prev_valid = 0;
                    prev_pos = '0;
                    prev_end = '0;
                end
                default: ;
            endcase
        endfunction

        task compare(string name, logic [23:0] got, logic [23:0] want);
            if (got !== want)
                report($sformatf("record %0d %s got %h expected %h", seen_records, name,
                                 got, want));
        endtask

        task check_record(logic [M_TDATA_W-1:0] data, logic user, logic lst);
            t_record want;
            if (pending_records.size() == 0) begin
                report($sformatf("record %0d arrived with nothing expected", seen_records));
            end else begin
                want = pending_records.pop_front();
                compare("record_kind", {23'b0, user}, {23'b0, want.kind});
                compare("last", {23'b0, lst}, {23'b0, want.last});
                compare("frag_index", {8'b0, data[15:0]}, {8'b0, want.index});
                compare("loc_term", {19'b0, data[20:16]}, {19'b0, want.term});
                compare("loc_offset", data[44:21], want.offset);
                compare("loc_len", {8'b0, data[60:45]}, {8'b0, want.len});
                compare("frag_start", data[84:61], want.start);
                compare("frag_bytes", data[108:85], want.bytes);
                compare("frag_score", data[132:109], want.score);
                compare("match_count", {8'b0, data[148:133]}, {8'b0, want.match_cnt});
                compare("token_total", data[172:149], want.tokens);
            end
            seen_records++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [S_TUSER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frag_record_checker tracker;
    int                 burst_left;
    logic [15:0]        cur_dist;
    logic [23:0]        gen_pos;
    logic [23:0]        gen_end;

    match_fragment_builder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int unsigned mode;
        int          mode_left;
        m_axis_tready = 1'b0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_record(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
    end

    task automatic send_req(input logic [1:0] kind, input logic [4:0] term,
                            input logic [23:0] pos, input logic [23:0] bpos,
                            input logic [15:0] len, input logic [15:0] wt);
        @(negedge i_clk);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {3'b0, wt, len, bpos, pos, term};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_request(kind, term, pos, bpos, len, wt);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_records.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_distance(input logic [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * REG_MAX_DISTANCE);
        pwdata <= {16'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[15:0] !== value)
            tracker.report($sformatf("max_distance read %h expected %h", prdata[15:0], value));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        tracker.max_dist = value;
        cur_dist = value;
    endtask

    task automatic directed_items();
        send_req(KIND_EOD, 5'd0, 24'd0, 24'd0, 16'd0, 16'd0);
        send_req(KIND_UNUSED, 5'd7, 24'd3, 24'd9, 16'd2, 16'd5);
        send_req(KIND_TOKEN, 5'd0, 24'd9, 24'd90, 16'd3, 16'd0);
        send_req(KIND_MATCH, 5'd0, 24'd10, 24'd100, 16'd5, 16'h0100);
        send_req(KIND_TOKEN, 5'd0, 24'd11, 24'd106, 16'd2, 16'd0);
        send_req(KIND_TOKEN, 5'd0, 24'd12, 24'd108, 16'd1, 16'd0);
        send_req(KIND_MATCH, 5'd1, 24'd13, 24'd110, 16'd3, 16'hFFFF);
        send_req(KIND_MATCH, 5'd1, 24'd15, 24'd120, 16'd4, 16'h0200);
        send_req(KIND_MATCH, 5'd2, 24'd15, 24'd200, 16'd4, 16'h0300);
        send_req(KIND_MATCH, 5'd2, 24'd16, 24'd121, 16'd4, 16'h0300);
        send_req(KIND_MATCH, 5'd2, 24'd24, 24'd130, 16'd0, 16'd0);
        send_req(KIND_MATCH, 5'd3, 24'd33, 24'd140, 16'd6, 16'h0080);
        send_req(KIND_MATCH, 5'd4, 24'd20, 24'd150, 16'd2, 16'h0040);
        send_req(KIND_MATCH, 5'd31, 24'hFF_FFFF, 24'hFF_FF00, 16'hFFFF, 16'hFFFF);
        send_req(KIND_MATCH, 5'd5, 24'd0, 24'hFF_FFFF, 16'd0, 16'h1234);
        send_req(KIND_EOD, 5'd0, 24'd0, 24'd0, 16'd0, 16'd0);
        send_req(KIND_EOD, 5'd31, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_req(KIND_MATCH, 5'd31, 24'd0, 24'd0, 16'd0, 16'd0);
        send_req(KIND_TOKEN, 5'd31, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_req(KIND_MATCH, 5'd30, 24'd1, 24'd0, 16'd1, 16'h00FF);
        send_req(KIND_EOD, 5'd0, 24'd0, 24'd0, 16'd0, 16'd0);
    endtask

    task automatic random_items(input int n);
        int          count;
        int unsigned sel;
        logic [4:0]  t;
        logic [23:0] p;
        logic [23:0] b;
        logic [15:0] l;
        logic [15:0] w;
        count = 0;
        while (count < n) begin
            sel = $urandom_range(0, 99);
            t = 5'($urandom);
            p = 24'($urandom);
            b = 24'($urandom);
            l = 16'($urandom);
            w = 16'($urandom);
            if (sel < 4) begin
                send_req(KIND_UNUSED, t, p, b, l, w);
            end else begin
                count++;
                if (sel < 10) begin
                    send_req(KIND_EOD, t, p, b, l, w);
                    if ($urandom_range(0, 3) == 0) begin
                        gen_pos = p;
                        gen_end = b;
                    end else begin
                        gen_pos = 24'($urandom_range(0, 1000));
                        gen_end = 24'($urandom_range(0, 5000));
                    end
                end else if (sel < 32) begin
                    send_req(KIND_TOKEN, t, p, b, l, w);
                end else if (sel < 40) begin
                    case ($urandom_range(0, 2))
                        0: p = gen_pos;
                        1: begin
                            p = gen_pos + 24'd1;
                            b = gen_end - 24'($urandom_range(1, 8));
                        end
                        default: ;
                    endcase
                    send_req(KIND_MATCH, t, p, b, l, w);
                end else begin
                    sel = $urandom_range(0, 99);
                    if (sel < 65)
                        gen_pos = gen_pos + 24'($urandom_range(1, 4));
                    else if (sel < 80)
                        gen_pos = gen_pos + {8'b0, cur_dist} + 24'($urandom_range(0, 2)) - 24'd1;
                    else if (sel < 90)
                        gen_pos = gen_pos + 24'($urandom_range(1, 200000));
                    else if (sel < 95)
                        gen_pos = gen_pos - 24'($urandom_range(1, 50));
                    if ($urandom_range(0, 4) != 0)
                        l = 16'($urandom_range(1, 24));
                    if ($urandom_range(0, 1) == 0)
                        t = 5'($urandom_range(0, 3));
                    sel = $urandom_range(0, 19);
                    if (sel == 0)
                        w = 16'hFFFF;
                    else if (sel == 1)
                        w = 16'd0;
                    b = gen_end + 24'($urandom_range(0, 40));
                    send_req(KIND_MATCH, t, gen_pos, b, l, w);
                    gen_end = b + {8'b0, l};
                end
            end
        end
    endtask

    initial begin
        int          w;
        logic [15:0] phase_dist[4];
        tracker = new();
        burst_left = 0;
        cur_dist = MAX_DIST_RST;
        gen_pos = '0;
        gen_end = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        phase_dist[0] = 16'd0;
        phase_dist[1] = 16'hFFFF;
        phase_dist[2] = 16'd1;
        phase_dist[3] = 16'($urandom_range(2, 300));
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_items();
        random_items(120);
        for (int i = 0; i < 4; i++) begin
            drain();
            set_distance(phase_dist[i]);
            random_items(120);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        for (w = 0; w < 20000 && tracker.pending_records.size() != 0; w++)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.pending_records.size() != 0)
            tracker.report($sformatf("%0d records never arrived",
                                     tracker.pending_records.size()));
        if (tracker.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- match_fragment_builder.f -----
+incdir+rtl
rtl/mfb_pkg.sv
rtl/mfb_regs.sv
rtl/mfb_front.sv
rtl/mfb_queue.sv
rtl/mfb_back.sv
rtl/match_fragment_builder.sv
rtl/mfb_checker.sv
bench/testbench.sv
